// File: hw/rtl/asbr_pkg.sv
`timescale 1ns / 1ps
package asbr_pkg;

  localparam int unsigned STACK_BYTES = 12;

  // configuration register indexes
  localparam logic [7:0] CFG_DOWNSTREAM_PREFIX     = 8'd0;
  localparam logic [7:0] CFG_DOWNSTREAM_PREFIX_LEN = 8'd1;
  localparam logic [7:0] CFG_UPSTREAM_ADDR         = 8'd2;

  localparam logic [5:0] PREFIX_LEN_RESET = 6'd24;
  localparam logic [5:0] PREFIX_LEN_MAX   = 6'd32;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_ACCEPT   = 2'd1,
    VERDICT_DROP     = 2'd2
  } asbr_verdict_e;

  // what the back end has to do with a header
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_PUSH,
    KIND_DROP,
    KIND_POP,
    KIND_KEEP
  } asbr_kind_e;

  typedef struct packed {
    logic        header_valid;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [63:0] src_stack_high;
    logic [31:0] src_stack_low;
    logic [7:0]  src_mark;
    logic [63:0] dst_stack_high;
    logic [31:0] dst_stack_low;
    logic [7:0]  dst_mark;
    logic [15:0] header_checksum;
  } asbr_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] source_addr_out;
    logic [31:0] dest_addr_out;
    logic [63:0] src_stack_high_out;
    logic [31:0] src_stack_low_out;
    logic [7:0]  src_mark_out;
    logic [7:0]  dst_mark_out;
    logic [15:0] checksum_out;
    logic        clear_zero_field;
  } asbr_out_t;

  typedef struct packed {
    logic [31:0] downstream_prefix;
    logic [5:0]  downstream_prefix_len;
    logic [31:0] upstream_addr;
  } asbr_cfg_t;

  // classified header as it sits in the queue
  typedef struct packed {
    asbr_kind_e  kind;
    logic [2:0]  shlen;
    logic [3:0]  new_mark;
    logic [31:0] csum_part;
    asbr_in_t    hdr;
  } asbr_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } asbr_qstat_t;

  // bytes moved per hop: (32 - min(len, 32)) / 8
  function automatic logic [2:0] shlen_of(input logic [5:0] len);
    logic [5:0] l;
    logic [5:0] rest;
    l    = (len > PREFIX_LEN_MAX) ? PREFIX_LEN_MAX : len;
    rest = PREFIX_LEN_MAX - l;
    return rest[5:3];
  endfunction

  // mask of the address bits that belong to the prefix
  function automatic logic [31:0] himask_of(input logic [2:0] shlen);
    logic [31:0] m;
    case (shlen)
      3'd0:    m = 32'hFFFF_FFFF;
      3'd1:    m = 32'hFFFF_FF00;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFF00_0000;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/address_stack_border_rewrite.sv
`timescale 1ns / 1ps
// A header is classified combinationally, written into the queue, and then moved into the output
// register when that register is empty or its word is being taken.
// Throughput: one header per cycle unless the queue is full or the output stalls; the classify
// stage is combinational and the rewrite stage is registered, parted by a queue of QueueDepth
// words, and the output register takes a new word in the cycle the old one leaves.
// Reset: queue and output register empty; prefix 0, prefix length 24, upstream address 0.
module address_stack_border_rewrite #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  asbr_pkg::asbr_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output asbr_pkg::asbr_out_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import asbr_pkg::*;

  asbr_cfg_t   cfg_q;
  asbr_qstat_t qstat;
  asbr_entry_t push_entry;
  asbr_entry_t head_entry;
  logic        push;
  logic        pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.downstream_prefix     <= '0;
      cfg_q.downstream_prefix_len <= PREFIX_LEN_RESET;
      cfg_q.upstream_addr         <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DOWNSTREAM_PREFIX:     cfg_q.downstream_prefix     <= cfg_data_i;
        CFG_DOWNSTREAM_PREFIX_LEN: cfg_q.downstream_prefix_len <= cfg_data_i[5:0];
        CFG_UPSTREAM_ADDR:         cfg_q.upstream_addr         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  asbr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  asbr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (qstat)
  );

  asbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .qstat_i     (qstat),
    .cfg_i       (cfg_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // only a rewritten accept clears the zero-check field
  a_clear_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.clear_zero_field |-> out_word_o.verdict == VERDICT_ACCEPT)
    else $error("zero-check clear without accept verdict");

  // an accepted header into an empty block reaches the output through the queue and the output register
  a_two_cycle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && qstat.empty && !out_valid_o |-> ##2 out_valid_o)
    else $error("header lost between queue and output");

  // a dropped header is never marked as rewritten
  a_drop_no_checksum_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.verdict == VERDICT_DROP |-> !out_word_o.clear_zero_field)
    else $error("dropped header marked as rewritten");

endmodule

// File: hw/rtl/asbr_front.sv
`timescale 1ns / 1ps
module asbr_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  asbr_pkg::asbr_in_t  in_word_i,
  input  asbr_pkg::asbr_cfg_t cfg_i,
  input  asbr_pkg::asbr_qstat_t qstat_i,
  output logic                push_o,
  output asbr_pkg::asbr_entry_t entry_o
);
  import asbr_pkg::*;

  logic [2:0]  shlen;
  logic [31:0] himask;
  logic [7:0]  mark_sum;
  logic        src_match;
  asbr_kind_e  kind;
  logic [31:0] from_addr;
  logic [32:0] part_sum;

  assign shlen     = shlen_of(cfg_i.downstream_prefix_len);
  assign himask    = himask_of(shlen);
  assign mark_sum  = in_word_i.src_mark + {5'd0, shlen};
  assign src_match = (in_word_i.source_addr & himask) == (cfg_i.downstream_prefix & himask);

  // source rule wins over the destination rule
  always_comb begin
    if (!in_word_i.header_valid) begin
      kind = KIND_PASS;
    end else if (src_match) begin
      kind = (mark_sum < 8'd12) ? KIND_PUSH : KIND_DROP;
    end else if (in_word_i.dest_addr == cfg_i.upstream_addr) begin
      kind = (in_word_i.dst_mark != 8'd0) ? KIND_POP : KIND_KEEP;
    end else begin
      kind = KIND_PASS;
    end
  end

  // first half of the incremental checksum patch: ~hc + ~from, end-around carry
  assign from_addr = (kind == KIND_POP) ? in_word_i.dest_addr : in_word_i.source_addr;
  assign part_sum  = {1'b0, 16'hFFFF, ~in_word_i.header_checksum} + {1'b0, ~from_addr};

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  assign entry_o.kind      = kind;
  assign entry_o.shlen     = shlen;
  assign entry_o.new_mark  = mark_sum[3:0];
  assign entry_o.csum_part = part_sum[31:0] + {31'd0, part_sum[32]};
  assign entry_o.hdr       = in_word_i;

endmodule

// File: hw/rtl/asbr_fifo.sv
`timescale 1ns / 1ps
module asbr_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  asbr_pkg::asbr_entry_t entry_i,
  input  logic                  pop_i,
  output asbr_pkg::asbr_entry_t entry_o,
  output asbr_pkg::asbr_qstat_t stat_o
);
  import asbr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  asbr_entry_t   slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: hw/rtl/asbr_back.sv
`timescale 1ns / 1ps
module asbr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  asbr_pkg::asbr_entry_t entry_i,
  input  asbr_pkg::asbr_qstat_t qstat_i,
  input  asbr_pkg::asbr_cfg_t   cfg_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output asbr_pkg::asbr_out_t   out_word_o
);
  import asbr_pkg::*;

  logic        valid_q;
  asbr_out_t   word_q, word_d;
  logic [7:0]  sbyte [STACK_BYTES];
  logic [7:0]  dbyte [STACK_BYTES];
  logic [7:0]  srcb  [4];
  logic [7:0]  pushed [STACK_BYTES];
  logic [31:0] new_dst;
  logic [31:0] to_addr;
  logic [32:0] sum2;
  logic [31:0] sum2_fold;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] new_csum;
  logic [63:0] new_shi;
  logic [31:0] new_slo;
  logic        advance;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sbyte[i] = entry_i.hdr.src_stack_high[8*(7-i) +: 8];
      dbyte[i] = entry_i.hdr.dst_stack_high[8*(7-i) +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      sbyte[8+i] = entry_i.hdr.src_stack_low[8*(3-i) +: 8];
      dbyte[8+i] = entry_i.hdr.dst_stack_low[8*(3-i) +: 8];
      srcb[i]    = entry_i.hdr.source_addr[8*(3-i) +: 8];
    end
  end

  // push: the low shlen source bytes land at stack positions 12 - mark + k;
  // positions past the end fall away when the mark wrapped
  always_comb begin
    logic [3:0] pos;
    logic [2:0] j;
    for (int i = 0; i < STACK_BYTES; i++) begin
      pushed[i] = sbyte[i];
      for (int k = 0; k < 4; k++) begin
        pos = 4'(4'd12 - entry_i.new_mark + 4'(k));
        j   = 3'(3'd4 - entry_i.shlen + 3'(k));
        if (3'(k) < entry_i.shlen && pos == 4'(i)) begin
          pushed[i] = srcb[j[1:0]];
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      new_shi[8*(7-i) +: 8] = pushed[i];
    end
    for (int i = 0; i < 4; i++) begin
      new_slo[8*(3-i) +: 8] = pushed[8+i];
    end
  end

  // pop: rebuild the destination under the prefix; bytes outside the stack read zero
  always_comb begin
    logic signed [9:0] p;
    logic [2:0]        j;
    logic [7:0]        b;
    new_dst = cfg_i.downstream_prefix & himask_of(entry_i.shlen);
    for (int k = 0; k < 4; k++) begin
      p = 10'sd12 - $signed({2'b00, entry_i.hdr.dst_mark}) + 10'(k);
      j = 3'(3'd4 - entry_i.shlen + 3'(k));
      b = (p >= 10'sd0 && p <= 10'sd11) ? dbyte[p[3:0]] : 8'd0;
      if (3'(k) < entry_i.shlen) begin
        new_dst[8*(3-j[1:0]) +: 8] = new_dst[8*(3-j[1:0]) +: 8] | b;
      end
    end
  end

  // second half of the checksum patch, then fold twice
  assign to_addr   = (entry_i.kind == KIND_POP) ? new_dst : cfg_i.upstream_addr;
  assign sum2      = {1'b0, entry_i.csum_part} + {1'b0, to_addr};
  assign sum2_fold = sum2[31:0] + {31'd0, sum2[32]};
  assign fold1     = {1'b0, sum2_fold[15:0]} + {1'b0, sum2_fold[31:16]};
  assign fold2     = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
  assign new_csum  = ~fold2[15:0];

  always_comb begin
    word_d.verdict            = VERDICT_CONTINUE;
    word_d.source_addr_out    = entry_i.hdr.source_addr;
    word_d.dest_addr_out      = entry_i.hdr.dest_addr;
    word_d.src_stack_high_out = entry_i.hdr.src_stack_high;
    word_d.src_stack_low_out  = entry_i.hdr.src_stack_low;
    word_d.src_mark_out       = entry_i.hdr.src_mark;
    word_d.dst_mark_out       = entry_i.hdr.dst_mark;
    word_d.checksum_out       = entry_i.hdr.header_checksum;
    word_d.clear_zero_field   = 1'b0;
    unique case (entry_i.kind)
      KIND_PASS: begin
        word_d.verdict = VERDICT_CONTINUE;
      end
      KIND_DROP: begin
        word_d.verdict = VERDICT_DROP;
      end
      KIND_KEEP: begin
        word_d.verdict = VERDICT_ACCEPT;
      end
      KIND_PUSH: begin
        word_d.verdict            = VERDICT_ACCEPT;
        word_d.source_addr_out    = cfg_i.upstream_addr;
        word_d.src_stack_high_out = new_shi;
        word_d.src_stack_low_out  = new_slo;
        word_d.src_mark_out       = {4'd0, entry_i.new_mark};
        word_d.checksum_out       = new_csum;
        word_d.clear_zero_field   = 1'b1;
      end
      KIND_POP: begin
        word_d.verdict          = VERDICT_ACCEPT;
        word_d.dest_addr_out    = new_dst;
        word_d.dst_mark_out     = entry_i.hdr.dst_mark - {5'd0, entry_i.shlen};
        word_d.checksum_out     = new_csum;
        word_d.clear_zero_field = 1'b1;
      end
      default: begin
        word_d.verdict = VERDICT_CONTINUE;
      end
    endcase
  end

  // refill the output word whenever it is empty or being taken
  assign advance = !valid_q || !out_stall_i;
  assign pop_o   = advance && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= !qstat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule
